>>> hw/rtl/pgd_pkg.sv
// Package for the packed identifier decoder: state and result types.
package pgd_pkg;

  localparam int unsigned LANE_BITS = 8;
  localparam int unsigned NUM_LANES = 8;
  localparam int unsigned ID_BITS   = LANE_BITS * NUM_LANES;

  typedef logic [LANE_BITS-1:0] lane_t;
  typedef logic [NUM_LANES-1:0] mask_t;
  typedef logic [ID_BITS-1:0]   ident_t;

  // Decoder state; pending == 0 means the next word is a mask.
  typedef struct packed {
    mask_t  pending;
    mask_t  orig_mask;
    ident_t acc;
  } pgd_state_t;

  typedef struct packed {
    ident_t identifier;
    mask_t  presence_mask;
    logic   truncated;
  } pgd_result_t;

endpackage

>>> hw/rtl/pgd_in_if.sv
// Input channel interface: one packet byte per word.
interface pgd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_end;

  modport source (output valid, output data_byte, output packet_end, input ready);
  modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

>>> hw/rtl/pgd_out_if.sv
// Result channel interface: one decoded identifier per word.
interface pgd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] identifier;
  logic [7:0]  presence_mask;
  logic        truncated;

  modport source (output valid, output identifier, output presence_mask, output truncated,
                  input ready);
  modport sink   (input valid, input identifier, input presence_mask, input truncated,
                  output ready);
endinterface

>>> hw/rtl/packed_guid_decoder_core.sv
// Top level: input register, decode step with state, result register.
//
//  channel  dir  payload                                 handshake
//  in_ch    in   data_byte[7:0], packet_end              valid/ready
//  out_ch   out  identifier[63:0], presence_mask[7:0],   valid/ready
//                truncated
//
// One word per cycle sustained while the result is not stalled; an emitted result
// passes from the input register through the combinational step to the result register.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to expecting a mask byte.
// A stalled result holds the input register; a new word is taken in the
// cycle the held result is taken.
module packed_guid_decoder_core
  import pgd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  pgd_in_if.sink   in_ch,
  pgd_out_if.source out_ch
);

  logic        s1_valid_r;
  lane_t       s1_byte_r;
  logic        s1_end_r;
  logic        s1_adv;

  pgd_state_t  state_r;
  pgd_state_t  state_nxt;
  logic        emit;
  pgd_result_t step_res;

  logic        out_valid_r;
  pgd_result_t out_r;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_end_r  <= in_ch.packet_end;
    end
  end

  pgd_lane_step u_step (
    .state_cur  (state_r),
    .data_byte  (s1_byte_r),
    .packet_end (s1_end_r),
    .state_nxt  (state_nxt),
    .emit       (emit),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_r <= step_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.identifier    = out_r.identifier;
  assign out_ch.presence_mask = out_r.presence_mask;
  assign out_ch.truncated     = out_r.truncated;

  // an emitted word always leaves the decoder expecting a mask
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && emit) |=> (state_r.pending == '0))
    else $error("pending lanes left after emit");

  // end of packet always closes the identifier
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_end_r) |=> (state_r.pending == '0 && out_valid_r))
    else $error("packet end did not close identifier");

  // truncation only happens for a nonzero mask
  a_trunc_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.truncated) |-> (out_r.presence_mask != '0))
    else $error("truncated result with empty mask");

  // input stalls only behind a held word
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without cause");

endmodule

>>> hw/rtl/pgd_lane_step.sv
// One decode step: mask capture or lane write, and the emit decision.
module pgd_lane_step
  import pgd_pkg::*;
(
  input  pgd_state_t  state_cur,
  input  lane_t       data_byte,
  input  logic        packet_end,
  output pgd_state_t  state_nxt,
  output logic        emit,
  output pgd_result_t result
);

  mask_t  lane_oh;
  mask_t  pend_left;
  ident_t acc_upd;

  // lowest pending lane as a one-hot
  assign lane_oh   = state_cur.pending & (~state_cur.pending + mask_t'(1));
  assign pend_left = state_cur.pending & ~lane_oh;

  always_comb begin
    acc_upd = state_cur.acc;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (lane_oh[i]) begin
        acc_upd[i*LANE_BITS +: LANE_BITS] = data_byte;
      end
    end
  end

  always_comb begin
    state_nxt = state_cur;
    emit      = 1'b0;
    result    = '0;
    if (state_cur.pending == '0) begin
      state_nxt.orig_mask = data_byte;
      state_nxt.acc       = '0;
      state_nxt.pending   = data_byte;
      result.presence_mask = data_byte;
      if (data_byte == '0) begin
        emit = 1'b1;
      end else if (packet_end) begin
        emit             = 1'b1;
        result.truncated = 1'b1;
        state_nxt.pending = '0;
      end
    end else begin
      state_nxt.acc        = acc_upd;
      state_nxt.pending    = pend_left;
      result.identifier    = acc_upd;
      result.presence_mask = state_cur.orig_mask;
      if (pend_left == '0) begin
        emit = 1'b1;
      end else if (packet_end) begin
        emit              = 1'b1;
        result.truncated  = 1'b1;
        state_nxt.pending = '0;
      end
    end
  end

endmodule
